[hdl/lru_pkg.sv]
// ----------------------------------------------------------------------------
// lru_pkg: shared types and constants for the recency list
// Slot and link widths, command codes, controller states and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

    localparam int ENTRIES = 256;
    // entry_index is a fixed 8-bit field, so the list covers all of its codes
    localparam int SLOT_W  = 8;
    // one extra bit encodes the null link
    localparam int LINK_W  = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

    localparam int CMD_W   = 2;
    localparam int OUT_USER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UNLINK,
        ST_LINK_A,
        ST_LINK_B,
        ST_REPLY
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_REFUSE,
        OP_CLEAR,
        OP_UNLINK,
        OP_LINK_A,
        OP_LINK_B,
        OP_REPLY
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic slot_listed;
        logic slot_is_head;
        logic tail_valid;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/lru_recency_list.sv]
// ----------------------------------------------------------------------------
// lru_recency_list: LRU recency order over 256 cache slots
// Doubly linked list in two link RAMs with head, tail and membership bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the command
//   (push front, move to front, pop least recent, clear) and s_tdata the
//   slot number. Every input word yields exactly one result word on
//   m_tvalid/m_tready: m_tdata holds the popped slot, m_tuser the flags.
//   Commands are handled one at a time. The sequencer does one link RAM
//   read, then one write per RAM per cycle for the unlink and relink
//   steps. The result appears on m_tvalid in the same cycle that s_tready
//   returns high for the next command.
//   A new word is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the next command holds in its
//   final step until the output register frees up.
//   Reset empties the list (head and tail null, all slots unlisted); the
//   link RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_recency_list (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lru_pkg::SLOT_W-1:0]    s_tdata,  // [7:0] entry_index
    input  wire logic [lru_pkg::CMD_W-1:0]     s_tuser,  // [1:0] command
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [lru_pkg::SLOT_W-1:0]    m_tdata,  // [7:0] popped_entry
    output logic      [lru_pkg::OUT_USER_W-1:0] m_tuser  // [0] popped_valid, [1] misuse_flag
);
    import lru_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t status;

    lru_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctl      (ctl)
    );

    lru_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .status   (status),
        .s_cmd    (cmd_t'(s_tuser)),
        .s_entry  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[hdl/lru_ram.sv]
// ----------------------------------------------------------------------------
// lru_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/lru_ctl.sv]
// ----------------------------------------------------------------------------
// lru_ctl: command sequencer for the recency list
// Walks each command through decode, unlink and relink steps and hands
// one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_ctl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire lru_pkg::dp_status_t status,
    output lru_pkg::ctl_cmd_t        ctl
);
    import lru_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.cmd)
                    CMD_PUSH:  state_next = status.slot_listed ? ST_REPLY : ST_LINK_A;
                    CMD_MOVE:  state_next = (status.slot_listed && !status.slot_is_head)
                                            ? ST_UNLINK : ST_REPLY;
                    CMD_POP:   state_next = status.tail_valid ? ST_UNLINK : ST_REPLY;
                    CMD_CLEAR: state_next = ST_REPLY;
                    default:   state_next = ST_REPLY;
                endcase
            end
            ST_UNLINK: state_next = (status.cmd == CMD_MOVE) ? ST_LINK_A : ST_REPLY;
            ST_LINK_A: state_next = ST_LINK_B;
            ST_LINK_B: state_next = ST_REPLY;
            ST_REPLY: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        ctl.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.op = OP_LOAD;
                end
            end
            ST_DECODE: begin
                if ((status.cmd == CMD_PUSH && status.slot_listed) ||
                    (status.cmd == CMD_MOVE && !status.slot_listed)) begin
                    ctl.op = OP_REFUSE;
                end else if (status.cmd == CMD_CLEAR) begin
                    ctl.op = OP_CLEAR;
                end
            end
            ST_UNLINK: ctl.op = OP_UNLINK;
            ST_LINK_A: ctl.op = OP_LINK_A;
            ST_LINK_B: ctl.op = OP_LINK_B;
            ST_REPLY: begin
                if (status.out_free) begin
                    ctl.op = OP_REPLY;
                end
            end
            default: ctl.op = OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    // a relink sequence always completes once started
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LINK_A |=> state_reg == ST_LINK_B)
        else $error("link sequence broken");
`endif

endmodule

`default_nettype wire

[hdl/lru_dp.sv]
// ----------------------------------------------------------------------------
// lru_dp: link memories, head/tail, membership bits and result register
// Executes one operation per cycle as directed by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire lru_pkg::ctl_cmd_t            ctl,
    output lru_pkg::dp_status_t               status,
    input  wire lru_pkg::cmd_t                s_cmd,
    input  wire logic [lru_pkg::SLOT_W-1:0]   s_entry,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [lru_pkg::SLOT_W-1:0]   m_tdata,
    output logic      [lru_pkg::OUT_USER_W-1:0] m_tuser
);
    import lru_pkg::*;

    cmd_t                  cmd_reg,    cmd_next;
    logic [SLOT_W-1:0]     slot_reg,   slot_next;
    logic [LINK_W-1:0]     head_reg,   head_next;
    logic [LINK_W-1:0]     tail_reg,   tail_next;
    logic [ENTRIES-1:0]    listed_reg, listed_next;
    logic [SLOT_W-1:0]     popped_reg, popped_next;
    logic                  pvalid_reg, pvalid_next;
    logic                  misuse_reg, misuse_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]     out_data_reg,  out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg,  out_user_next;

    logic                  next_we, prev_we;
    logic [SLOT_W-1:0]     next_wa, prev_wa, rd_addr;
    logic [LINK_W-1:0]     next_wd, prev_wd;
    logic [LINK_W-1:0]     next_rd, prev_rd;

    // pop reads the tail node, push and move read the command slot
    assign rd_addr = (cmd_reg == CMD_POP) ? tail_reg[SLOT_W-1:0] : slot_reg;

    lru_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    lru_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (prev_we),
        .wr_addr (prev_wa),
        .wr_data (prev_wd),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    always_comb begin
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        listed_next    = listed_reg;
        popped_next    = popped_reg;
        pvalid_next    = pvalid_reg;
        misuse_next    = misuse_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;
        next_we        = 1'b0;
        next_wa        = slot_reg;
        next_wd        = head_reg;
        prev_we        = 1'b0;
        prev_wa        = slot_reg;
        prev_wd        = NIL_LINK;

        unique case (ctl.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                cmd_next    = s_cmd;
                slot_next   = s_entry;
                popped_next = '0;
                pvalid_next = 1'b0;
                misuse_next = 1'b0;
            end
            OP_REFUSE: begin
                misuse_next = 1'b1;
            end
            OP_CLEAR: begin
                head_next   = NIL_LINK;
                tail_next   = NIL_LINK;
                listed_next = '0;
            end
            OP_UNLINK: begin
                // splice the node out: prev_rd and next_rd are its neighbors
                if (!prev_rd[SLOT_W]) begin
                    next_we = 1'b1;
                    next_wa = prev_rd[SLOT_W-1:0];
                    next_wd = next_rd;
                end else begin
                    head_next = next_rd;
                end
                if (!next_rd[SLOT_W]) begin
                    prev_we = 1'b1;
                    prev_wa = next_rd[SLOT_W-1:0];
                    prev_wd = prev_rd;
                end else begin
                    tail_next = prev_rd;
                end
                if (cmd_reg == CMD_POP) begin
                    listed_next[tail_reg[SLOT_W-1:0]] = 1'b0;
                    popped_next = tail_reg[SLOT_W-1:0];
                    pvalid_next = 1'b1;
                end
            end
            OP_LINK_A: begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            OP_LINK_B: begin
                if (!head_reg[SLOT_W]) begin
                    prev_we = 1'b1;
                    prev_wa = head_reg[SLOT_W-1:0];
                    prev_wd = {1'b0, slot_reg};
                end else begin
                    tail_next = {1'b0, slot_reg};
                end
                head_next             = {1'b0, slot_reg};
                listed_next[slot_reg] = 1'b1;
            end
            OP_REPLY: begin
                out_valid_next = 1'b1;
                out_data_next  = popped_reg;
                out_user_next  = {misuse_reg, pvalid_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= NIL_LINK;
            tail_reg      <= NIL_LINK;
            listed_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            listed_reg    <= listed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        popped_reg   <= popped_next;
        pvalid_reg   <= pvalid_next;
        misuse_reg   <= misuse_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign status.cmd          = cmd_reg;
    assign status.slot_listed  = listed_reg[slot_reg];
    assign status.slot_is_head = (head_reg == {1'b0, slot_reg});
    assign status.tail_valid   = !tail_reg[SLOT_W];
    assign status.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg[SLOT_W] == tail_reg[SLOT_W])
        else $error("head and tail disagree on empty list");

    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg[SLOT_W] == (listed_reg == '0))
        else $error("membership bits disagree with empty list");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !tail_reg[SLOT_W] |-> listed_reg[tail_reg[SLOT_W-1:0]])
        else $error("tail slot not marked listed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_user_reg[0] |-> !out_user_reg[1])
        else $error("pop reported together with misuse");
`endif

endmodule

`default_nettype wire
